// ===== src/crp_pkg.sv =====
package crp_pkg;

    localparam int MAX_CHANNELS_DEF = 15;
    localparam int CAL_FIELDS_DEF   = 3;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] END_TAG    = 8'hff;
    localparam logic [7:0] CAL_TAG    = 8'h04;
    localparam logic [3:0] LAYOUT_TWO = 4'h2;
    localparam logic [15:0] MIN_BUFFER = 16'd4;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_INCOMPLETE = 4'd1,
        ST_EMPTY      = 4'd2,
        ST_CHECK      = 4'd3,
        ST_LAYOUT     = 4'd4,
        ST_SIZE       = 4'd5,
        ST_OVERRUN    = 4'd6,
        ST_DUPLICATE  = 4'd7,
        ST_ITEM_SIZE  = 4'd8,
        ST_MISSING    = 4'd9
    } status_t;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } byte_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel;
        logic [1:0]  field_index;
        logic [63:0] cal_value;
        logic [3:0]  status;
        logic        last;
    } result_t;

endpackage

// ===== src/calibration_record_parser.sv =====
// Calibration record parser.
// Input channel: one record byte per beat (byte_item), accepted when push is
//   high and full is low. start_req marks offset zero and restarts the parse.
// Result channel: queue-style; while empty is low the oldest result sits on
//   result, and it leaves on a clock edge with pop high.
// Each result is either one 64-bit calibration word (kind 0, with channel and
//   field) or the single final status of a record (kind 1, last 1). Commit
//   the words downstream only when that status is ok.
// Config: cfg_we/cfg_data write buffer_size at once; write it while idle.
// Throughput: one byte per cycle while full is low. The front parser classifies a
//   byte in the cycle it arrives; its result enters a small result queue.
// Latency: a result is queued at the edge that takes its byte, behind older ones.
// Stall: when pop is held low the queue fills and full rises, which holds
//   off further bytes; nothing is dropped.
// Reset: rst_n clears the parser to idle, buffer_size to zero and empties the
//   queue. Bytes without start_req while idle are ignored.
module calibration_record_parser #(
    parameter int MAX_CHANNELS = crp_pkg::MAX_CHANNELS_DEF,
    parameter int CAL_FIELDS   = crp_pkg::CAL_FIELDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                push,
    output logic                full,
    input  crp_pkg::byte_item_t byte_item,
    output logic                empty,
    input  logic                pop,
    output crp_pkg::result_t    result
);
    import crp_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;

    // Take a byte only while the result queue can absorb its result.
    assign accept = push && !full;

    crp_front #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .CAL_FIELDS  (CAL_FIELDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (accept),
        .in_item  (byte_item),
        .res_valid(res_valid),
        .res      (res)
    );

    crp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_valid),
        .wr_data(res),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .rd_data(result)
    );

endmodule

// ===== src/crp_front.sv =====
module crp_front #(
    parameter int MAX_CHANNELS = 15,
    parameter int CAL_FIELDS   = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    input  crp_pkg::byte_item_t in_item,
    output logic                res_valid,
    output crp_pkg::result_t    res
);
    import crp_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_CHECK   = 8'b0000_0010,
        PH_SIZE_LO = 8'b0000_0100,
        PH_SIZE_HI = 8'b0000_1000,
        PH_TAG     = 8'b0001_0000,
        PH_LEN     = 8'b0010_0000,
        PH_DATA    = 8'b0100_0000,
        PH_SKIP    = 8'b1000_0000
    } phase_t;

    localparam logic [3:0] MAX_CH  = 4'(MAX_CHANNELS);
    localparam logic [1:0] LAST_FD = 2'(CAL_FIELDS - 1);
    localparam logic [8:0] WORD_BYTES = 9'(8 * CAL_FIELDS);

    phase_t      phase_reg, phase_next;
    logic [15:0] buf_size_reg;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] total_reg, total_next;
    logic [3:0]  ch_count_reg, ch_count_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] end_reg, end_next;
    logic        seen_reg, seen_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  biw_reg, biw_next;
    logic [3:0]  chan_reg, chan_next;
    logic [1:0]  field_reg, field_next;

    logic [7:0]  b;
    logic [16:0] cur_p1;
    logic [16:0] item_stop;
    logic [8:0]  want_len;
    logic [63:0] word_val;

    assign b         = in_item.data_byte;
    assign cur_p1    = {1'b0, offset_reg} + 17'd1;
    assign item_stop = cur_p1 + {9'd0, b};
    assign want_len  = 9'(WORD_BYTES * ch_count_reg);
    assign word_val  = shift_reg | ({56'd0, b} << {biw_reg, 3'b000});

    always_comb
    begin
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        total_next    = total_reg;
        ch_count_next = ch_count_reg;
        tag_next      = tag_reg;
        end_next      = end_reg;
        seen_next     = seen_reg;
        shift_next    = shift_reg;
        biw_next      = biw_reg;
        chan_next     = chan_reg;
        field_next    = field_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.kind      = KIND_STATUS;
        res.last      = 1'b1;
        if (in_valid && in_item.start_req)
        begin
            offset_next = 16'd1;
            total_next  = '0;
            seen_next   = 1'b0;
            shift_next  = '0;
            biw_next    = '0;
            chan_next   = '0;
            field_next  = '0;
            end_next    = '0;
            if (buf_size_reg <= MIN_BUFFER)
            begin
                res_valid  = 1'b1;
                res.status = ST_INCOMPLETE;
                phase_next = PH_IDLE;
            end
            else if (b == END_TAG)
            begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
                phase_next = PH_IDLE;
            end
            else
            begin
                tag_next      = b;
                ch_count_next = b[7:4];
                phase_next    = PH_CHECK;
            end
        end
        else if (in_valid && phase_reg != PH_IDLE)
        begin
            offset_next = cur_p1[15:0];
            case (phase_reg)
                PH_CHECK:
                begin
                    if (~tag_reg != b)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_CHECK;
                        phase_next = PH_IDLE;
                    end
                    else if (tag_reg[3:0] != LAYOUT_TWO || ch_count_reg > MAX_CH)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_LAYOUT;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_SIZE_LO;
                    end
                end
                PH_SIZE_LO:
                begin
                    total_next = {8'd0, b};
                    phase_next = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    total_next = {b, total_reg[7:0]};
                    if ({b, total_reg[7:0]} > buf_size_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_SIZE;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    if (b == END_TAG)
                    begin
                        res_valid  = 1'b1;
                        res.status = seen_reg ? ST_OK : ST_MISSING;
                        phase_next = PH_IDLE;
                    end
                    else if (cur_p1 >= {1'b0, total_reg})
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_OVERRUN;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        tag_next   = b;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (item_stop >= {1'b0, total_reg})
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_OVERRUN;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        end_next = item_stop[15:0];
                        if (tag_reg == CAL_TAG)
                        begin
                            if (seen_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_DUPLICATE;
                                phase_next = PH_IDLE;
                            end
                            else if ({1'b0, b} != want_len)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_ITEM_SIZE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                seen_next  = 1'b1;
                                shift_next = '0;
                                biw_next   = '0;
                                chan_next  = '0;
                                field_next = '0;
                                phase_next = (b == 8'd0) ? PH_TAG : PH_DATA;
                            end
                        end
                        else
                        begin
                            phase_next = (b == 8'd0) ? PH_TAG : PH_SKIP;
                        end
                    end
                end
                PH_DATA:
                begin
                    shift_next = word_val;
                    biw_next   = biw_reg + 3'd1;
                    if (biw_reg == 3'd7)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_WORD;
                        res.last        = 1'b0;
                        res.status      = ST_OK;
                        res.channel     = chan_reg;
                        res.field_index = field_reg;
                        res.cal_value   = word_val;
                        shift_next      = '0;
                        if (field_reg >= LAST_FD)
                        begin
                            field_next = '0;
                            chan_next  = chan_reg + 4'd1;
                        end
                        else
                        begin
                            field_next = field_reg + 2'd1;
                        end
                    end
                    if (cur_p1 >= {1'b0, end_reg})
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_SKIP:
                begin
                    if (cur_p1 >= {1'b0, end_reg})
                    begin
                        phase_next = PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            buf_size_reg <= '0;
            offset_reg   <= '0;
            total_reg    <= '0;
            ch_count_reg <= '0;
            tag_reg      <= '0;
            end_reg      <= '0;
            seen_reg     <= 1'b0;
            shift_reg    <= '0;
            biw_reg      <= '0;
            chan_reg     <= '0;
            field_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                buf_size_reg <= cfg_data;
            end
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            total_reg    <= total_next;
            ch_count_reg <= ch_count_next;
            tag_reg      <= tag_next;
            end_reg      <= end_next;
            seen_reg     <= seen_next;
            shift_reg    <= shift_next;
            biw_reg      <= biw_next;
            chan_reg     <= chan_next;
            field_reg    <= field_next;
        end
    end

endmodule

// ===== src/crp_queue.sv =====
module crp_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  crp_pkg::result_t wr_data,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output crp_pkg::result_t rd_data
);
    import crp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    result_t       slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow queue");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not shrink queue");

endmodule

// ===== sim/tb_calibration_record_parser.sv =====
`timescale 1ns / 100ps

module tb_calibration_record_parser;
    import crp_pkg::*;

    // Stop the run after this many cycles in which no beat moves on either side.
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 1650;
    localparam int CALM_TAIL   = 150;

    typedef enum logic [2:0] {
        PH_IDLE, PH_CHECK, PH_SIZE_LO, PH_SIZE_HI, PH_TAG, PH_LEN, PH_DATA, PH_SKIP
    } phase_t;

    // One row of the directed table: either a register write or a byte beat.
    // A row marked typed carries the final status that it must produce.
    typedef struct {
        logic        is_cfg;
        logic [15:0] val;
        logic        st;
        logic        typed;
        status_t     want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [15:0] cfg_data;
    logic       push;
    logic       full;
    byte_item_t byte_item;
    logic       empty;
    logic       pop;
    result_t    result;

    result_t    expected_results[$];
    int         mismatches;
    int         quiet_cycles;
    int         parsed_bytes;
    logic       gaps_on;
    logic       hold_req;

    // Shadow state of the parser.
    logic [15:0] buf_size;
    phase_t      phase;
    logic [15:0] offs;
    logic [15:0] tot_size;
    logic [3:0]  chan_cnt;
    logic [7:0]  cur_tag;
    logic [15:0] item_stop;
    logic        cal_found;
    logic [63:0] word_acc;
    logic [3:0]  word_bytes;
    logic [3:0]  word_chan;
    logic [1:0]  word_field;

    calibration_record_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .byte_item (byte_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always #5 clk = ~clk;

    // Close the record: go idle and emit the single status beat.
    function automatic void close_record(output result_t r, input status_t s);
        phase    = PH_IDLE;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = s;
        r.last   = 1'b1;
    endfunction

    // Advance the shadow parser by one byte; return 1 when it yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                      output result_t r);
        int cur;
        int stop;
        r = '0;
        if (st) begin
            offs       = 16'd1;
            tot_size   = '0;
            cal_found  = 1'b0;
            word_acc   = '0;
            word_bytes = '0;
            word_chan  = '0;
            word_field = '0;
            item_stop  = '0;
            if (buf_size <= MIN_BUFFER) begin
                close_record(r, ST_INCOMPLETE);
                return 1'b1;
            end
            if (b == END_TAG) begin
                close_record(r, ST_EMPTY);
                return 1'b1;
            end
            cur_tag  = b;
            chan_cnt = b[7:4];
            phase    = PH_CHECK;
            return 1'b0;
        end
        if (phase == PH_IDLE)
            return 1'b0;
        cur  = offs;
        offs = offs + 16'd1;
        case (phase)
            PH_CHECK: begin
                if (~cur_tag != b) begin
                    close_record(r, ST_CHECK);
                    return 1'b1;
                end
                if (cur_tag[3:0] != LAYOUT_TWO || int'(chan_cnt) > MAX_CHANNELS_DEF) begin
                    close_record(r, ST_LAYOUT);
                    return 1'b1;
                end
                phase = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
                tot_size = {8'h00, b};
                phase    = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
                tot_size[15:8] = b;
                if (tot_size > buf_size) begin
                    close_record(r, ST_SIZE);
                    return 1'b1;
                end
                phase = PH_TAG;
            end
            PH_TAG: begin
                if (b == END_TAG) begin
                    close_record(r, cal_found ? ST_OK : ST_MISSING);
                    return 1'b1;
                end
                if (cur + 1 >= int'(tot_size)) begin
                    close_record(r, ST_OVERRUN);
                    return 1'b1;
                end
                cur_tag = b;
                phase   = PH_LEN;
            end
            PH_LEN: begin
                stop = cur + 1 + int'(b);
                if (stop >= int'(tot_size)) begin
                    close_record(r, ST_OVERRUN);
                    return 1'b1;
                end
                item_stop = stop[15:0];
                if (cur_tag == CAL_TAG) begin
                    if (cal_found) begin
                        close_record(r, ST_DUPLICATE);
                        return 1'b1;
                    end
                    if (int'(b) != 8 * CAL_FIELDS_DEF * int'(chan_cnt)) begin
                        close_record(r, ST_ITEM_SIZE);
                        return 1'b1;
                    end
                    cal_found  = 1'b1;
                    word_acc   = '0;
                    word_bytes = '0;
                    word_chan  = '0;
                    word_field = '0;
                    phase      = (b == 8'd0) ? PH_TAG : PH_DATA;
                end else begin
                    phase = (b == 8'd0) ? PH_TAG : PH_SKIP;
                end
            end
            PH_DATA: begin
                word_acc   = word_acc | (64'(b) << (word_bytes[2:0] * 8));
                word_bytes = word_bytes + 4'd1;
                if (cur + 1 >= int'(item_stop))
                    phase = PH_TAG;
                if (word_bytes >= 4'd8) begin
                    r.kind        = KIND_WORD;
                    r.channel     = word_chan;
                    r.field_index = word_field;
                    r.cal_value   = word_acc;
                    word_acc      = '0;
                    word_bytes    = '0;
                    if (int'(word_field) + 1 >= CAL_FIELDS_DEF) begin
                        word_field = '0;
                        word_chan  = word_chan + 4'd1;
                    end else begin
                        word_field = word_field + 2'd1;
                    end
                    return 1'b1;
                end
            end
            PH_SKIP: begin
                if (cur + 1 >= int'(item_stop))
                    phase = PH_TAG;
            end
            default: phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // Offer one beat from a falling edge; hold it until the block takes it.
    // If typed, the given status replaces the predicted expectation.
    task automatic send_beat(input logic [7:0] b, input logic st,
                             input logic typed, input status_t want);
        result_t r;
        bit      hit;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        push                = 1'b1;
        byte_item.data_byte = b;
        byte_item.start_req = st;
        forever begin
            @(posedge clk);
            if (!full)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        hit = parse_byte(b, st, r);
        parsed_bytes++;
        if (typed) begin
            r        = '0;
            r.kind   = KIND_STATUS;
            r.status = want;
            r.last   = 1'b1;
            hit      = 1'b1;
        end
        if (hit)
            expected_results.push_back(r);
    endtask

    // Drain every expected result, let the pipeline settle, then write the register.
    task automatic write_buffer_size(input logic [15:0] v);
        push = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we   = 1'b0;
        buf_size = v;
    endtask

    // Build one record, mostly well formed, with occasional damage.
    task automatic send_record();
        logic [7:0]  rec[$];
        logic [7:0]  ver;
        logic [7:0]  len;
        logic [15:0] total;
        int          ch;
        int          n_skip;
        int          cal_at;
        int          stop_at;
        ch     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        ver    = {4'(ch), ($urandom_range(0, 9) == 0) ? 4'($urandom) : LAYOUT_TWO};
        n_skip = $urandom_range(0, 3);
        cal_at = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, n_skip);
        rec.push_back(ver);
        rec.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : ~ver);
        rec.push_back(8'h00);
        rec.push_back(8'h00);
        for (int i = 0; i <= n_skip; i++) begin
            if (i == cal_at || (i == n_skip && $urandom_range(0, 19) == 0)) begin
                len = 8'(8 * CAL_FIELDS_DEF * ch);
                if ($urandom_range(0, 19) == 0)
                    len = len + 8'd8;
                rec.push_back(CAL_TAG);
                rec.push_back(len);
                repeat (int'(len)) rec.push_back(8'($urandom));
            end else if (i < n_skip) begin
                do
                    ver = 8'($urandom);
                while (ver == CAL_TAG || ver == END_TAG);
                len = 8'($urandom_range(0, 6));
                rec.push_back(ver);
                rec.push_back(len);
                repeat (int'(len)) rec.push_back(8'($urandom));
            end
        end
        rec.push_back(END_TAG);
        total = 16'(rec.size() + $urandom_range(1, 4));
        if ($urandom_range(0, 9) == 0)
            total = 16'($urandom_range(4, rec.size()));
        else if ($urandom_range(0, 29) == 0)
            total = 16'($urandom);
        rec[2] = total[7:0];
        rec[3] = total[15:8];
        if ($urandom_range(0, 9) == 0)
            rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom);
        stop_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, rec.size()) : rec.size();
        for (int i = 0; i < stop_at; i++)
            send_beat(rec[i], i == 0, 1'b0, ST_OK);
    endtask

    // Receiver: random pop gaps, plus one long hold-off on request.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                pop      = 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end else if (gaps_on && $urandom_range(0, 11) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            pop = 1'b1;
        end
    end

    // Check each popped result against the oldest expectation.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                report("result with nothing expected", result.cal_value, 64'(0));
            end else begin
                e = expected_results.pop_front();
                if (result.kind != e.kind)
                    report("kind", 64'(result.kind), 64'(e.kind));
                if (result.channel != e.channel)
                    report("channel", 64'(result.channel), 64'(e.channel));
                if (result.field_index != e.field_index)
                    report("field_index", 64'(result.field_index), 64'(e.field_index));
                if (result.cal_value != e.cal_value)
                    report("cal_value", result.cal_value, e.cal_value);
                if (result.status != e.status)
                    report("status", 64'(result.status), 64'(e.status));
                if (result.last != e.last)
                    report("last", 64'(result.last), 64'(e.last));
            end
        end
    end

    // Watchdog: count cycles without any beat on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_tab[$];
        int       rec_cnt;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        push         = 1'b0;
        byte_item    = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        parsed_bytes = 0;
        gaps_on      = 1'b1;
        hold_req     = 1'b0;
        buf_size     = '0;
        phase        = PH_IDLE;
        offs         = '0;
        tot_size     = '0;
        chan_cnt     = '0;
        cur_tag      = '0;
        item_stop    = '0;
        cal_found    = 1'b0;
        word_acc     = '0;
        word_bytes   = '0;
        word_chan    = '0;
        word_field   = '0;

        // Short buffer straight after reset, then the full range.
        dir_tab.push_back('{1'b0, 16'h22, 1'b1, 1'b1, ST_INCOMPLETE});
        dir_tab.push_back('{1'b1, 16'hffff, 1'b0, 1'b0, ST_OK});
        // Idle byte is dropped; empty marker.
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hff, 1'b1, 1'b1, ST_EMPTY});
        // Bad complement, then bad layout.
        dir_tab.push_back('{1'b0, 16'h12, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b1, ST_CHECK});
        dir_tab.push_back('{1'b0, 16'h13, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hec, 1'b0, 1'b1, ST_LAYOUT});
        // Zero channels, empty calibration item: ok.
        dir_tab.push_back('{1'b0, 16'h02, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hfd, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h08, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h04, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hff, 1'b0, 1'b1, ST_OK});
        // Terminator without a calibration item.
        dir_tab.push_back('{1'b0, 16'h12, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hed, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h10, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hff, 1'b0, 1'b1, ST_MISSING});
        // Tag at the last byte of the record overruns; a restart mid-record abandons it.
        dir_tab.push_back('{1'b0, 16'h02, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hfd, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h02, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hfd, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h05, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h04, 1'b0, 1'b1, ST_OVERRUN});
        // Declared size beyond a five-byte buffer.
        dir_tab.push_back('{1'b1, 16'h0005, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h22, 1'b1, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'hdd, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h10, 1'b0, 1'b0, ST_OK});
        dir_tab.push_back('{1'b0, 16'h00, 1'b0, 1'b1, ST_SIZE});

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg)
                write_buffer_size(dir_tab[i].val);
            else
                send_beat(dir_tab[i].val[7:0], dir_tab[i].st, dir_tab[i].typed,
                          dir_tab[i].want);
        end
        write_buffer_size(16'hffff);

        rec_cnt = 0;
        while (parsed_bytes < ITEM_TARGET) begin
            gaps_on = (parsed_bytes < ITEM_TARGET - CALM_TAIL);
            if (rec_cnt == 20)
                hold_req = 1'b1;
            // Revisit the register now and then, extremes included.
            if (rec_cnt % 8 == 7) begin
                case ($urandom_range(0, 7))
                    0:       write_buffer_size(16'h0000);
                    1:       write_buffer_size(MIN_BUFFER);
                    2:       write_buffer_size(MIN_BUFFER + 16'd1);
                    3:       write_buffer_size(16'($urandom));
                    4:       write_buffer_size(16'($urandom_range(5, 40)));
                    default: write_buffer_size(16'hffff);
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0, ST_OK);
            send_record();
            rec_cnt++;
        end

        push = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/crp_pkg.sv
src/crp_front.sv
src/crp_queue.sv
src/calibration_record_parser.sv
sim/tb_calibration_record_parser.sv
